// ----- hdl/nnrs_pkg.sv -----
// Shared types, codes and default sizes for the nearest-neighbor RGBA scaler.
// No dependencies.
package nnrs_pkg;

  localparam int unsigned DEF_MAX_DIM         = 4096;
  localparam longint unsigned DEF_MAX_PIXEL_COUNT = 64'd16777216;
  localparam int unsigned DEF_STORE_WORDS     = 1048576;

  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LADDR_W = 20;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // numerator (2c+1)*dim, denominator 2*dim, quotient below dim
  localparam int unsigned NUM_W = 2 * DIM_W;
  localparam int unsigned DEN_W = DIM_W + 1;
  localparam int unsigned QUO_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_ROW_PITCH  = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4,
    REG_BGRA_ORDER = 3'd5,
    REG_FLIP_ROWS  = 3'd6
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SRC   = 2'd1,
    ST_BAD_OUT   = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic               cmd;
    logic [LADDR_W-1:0] load_address;
    logic [PIX_W-1:0]   load_pixel;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0]   src_width;
    logic [DIM_W-1:0]   src_height;
    logic [PITCH_W-1:0] row_pitch_words;
    logic [DIM_W-1:0]   out_width;
    logic [DIM_W-1:0]   out_height;
    logic               bgra_order;
    logic               flip_rows;
    logic               src_bad;
    logic               out_bad;
  } cfg_t;

  // data that rides alongside the divider pipeline
  typedef struct packed {
    logic               cmd;
    logic [LADDR_W-1:0] load_address;
    logic [PIX_W-1:0]   load_pixel;
    logic [1:0]         status;
  } side_t;

endpackage

// ----- hdl/nearest_neighbor_rgba_scaler_unit.sv -----
// Top level of the nearest-neighbor RGBA scaler.
// Depends on nnrs_pkg, nnrs_cfg, nnrs_div, nnrs_ram.
//
// Usage:
//   in_*  : words of a command stream. cmd LOAD writes load_pixel into the source
//           store at load_address (ignored beyond the store); cmd FETCH samples the
//           source at output coordinate (out_x, out_y).
//   out_* : one word per FETCH: R,G,B,A and status; loads return nothing.
//   cfg_* : write-only registers; the user must write them only while the block is
//           idle, not enforced by the block. Geometry checks settle the cycle after the last write.
// Throughput: one word per cycle while out_stall does not hold a result. After the
//   accepting edge a word passes the numerator multiply, 13 divider stages, address
//   multiply, store read and output register.
// Loads and fetches reach the store at the same stage in order, so a fetch
//   always sees every earlier load.
// Reset clears the pipeline valids and the config registers; pipeline data and the store are not cleared.
// When out_stall holds a result, the whole pipeline freezes and in_stall rises.
module nearest_neighbor_rgba_scaler_unit import nnrs_pkg::*; #(
  parameter int unsigned     MAX_DIM         = DEF_MAX_DIM,
  parameter longint unsigned MAX_PIXEL_COUNT = DEF_MAX_PIXEL_COUNT,
  parameter int unsigned     STORE_WORDS     = DEF_STORE_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned PW = PITCH_W + QUO_W;
  localparam int unsigned XW = (PW > LADDR_W ? PW : LADDR_W) + 1;

  cfg_t cfg;
  logic en;

  in_word_t s0_r;
  logic     v0_r, v1_r, v2_r, v3_r, out_valid_r;
  side_t    side0, side1_r, side2_r, side3_r;
  side_t    sd_r [QUO_W];
  logic     vd_r [QUO_W];
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [QUO_W-1:0] sx_q, sy_q, sy_f;
  logic [PW-1:0]    prod_r;
  logic [QUO_W-1:0] sx_r;
  logic [XW-1:0]    fetch_addr, load_addr_x;
  logic             ram_we, ram_re;
  logic [PIX_W-1:0] rdata;
  logic [1:0]       status0;
  out_word_t        out_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  nnrs_cfg #(.MAX_DIM(MAX_DIM), .MAX_PIXEL_COUNT(MAX_PIXEL_COUNT),
             .STORE_WORDS(STORE_WORDS)) u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg
  );

  always_comb begin
    if (cfg.out_bad) begin
      status0 = ST_BAD_OUT;
    end else if (cfg.src_bad) begin
      status0 = ST_BAD_SRC;
    end else if (DIM_W'(s0_r.out_x) >= cfg.out_width ||
                 DIM_W'(s0_r.out_y) >= cfg.out_height) begin
      status0 = ST_OUT_RANGE;
    end else begin
      status0 = ST_OK;
    end
    side0 = '{cmd: s0_r.cmd, load_address: s0_r.load_address,
              load_pixel: s0_r.load_pixel, status: status0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUO_W; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      vd_r[0] <= v1_r;
      for (int i = 1; i < QUO_W; i++) vd_r[i] <= vd_r[i-1];
      v2_r <= vd_r[QUO_W-1];
      v3_r <= v2_r;
      out_valid_r <= v3_r && (side3_r.cmd == CMD_FETCH);
    end
  end

  // numerators (2c+1)*dim
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r    <= in_word;
      side1_r <= side0;
      numx_r  <= NUM_W'({DIM_W'(s0_r.out_x), 1'b1}) * NUM_W'(cfg.src_width);
      numy_r  <= NUM_W'({DIM_W'(s0_r.out_y), 1'b1}) * NUM_W'(cfg.src_height);
      sd_r[0] <= side1_r;
      for (int i = 1; i < QUO_W; i++) sd_r[i] <= sd_r[i-1];
      side2_r <= sd_r[QUO_W-1];
      sx_r    <= sx_q;
      prod_r  <= PW'(sy_f) * PW'(cfg.row_pitch_words);
      side3_r <= side2_r;
    end
  end

  nnrs_div u_div_x (.clk, .en, .num(numx_r), .den({cfg.out_width, 1'b0}), .quo(sx_q));
  nnrs_div u_div_y (.clk, .en, .num(numy_r), .den({cfg.out_height, 1'b0}), .quo(sy_q));

  assign sy_f = cfg.flip_rows ? (cfg.src_height - DIM_W'(1) - sy_q) : sy_q;

  assign fetch_addr  = XW'(prod_r) + XW'(sx_r);
  assign load_addr_x = XW'(side2_r.load_address);
  assign ram_we = en && v2_r && (side2_r.cmd == CMD_LOAD)
               && (64'(load_addr_x) < 64'(STORE_WORDS));
  assign ram_re = en;

  nnrs_ram #(.WIDTH(PIX_W), .DEPTH(STORE_WORDS)) u_store (
    .clk,
    .we(ram_we),
    .waddr(load_addr_x[AW-1:0]),
    .wdata(side2_r.load_pixel),
    .re(ram_re),
    .raddr(fetch_addr[AW-1:0]),
    .rdata
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (side3_r.status != ST_OK) begin
        out_r <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
                   status: side3_r.status};
      end else begin
        out_r <= '{red:   cfg.bgra_order ? rdata[23:16] : rdata[7:0],
                   green: rdata[15:8],
                   blue:  cfg.bgra_order ? rdata[7:0] : rdata[23:16],
                   alpha: rdata[31:24],
                   status: side3_r.status};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |->
      out_r.red == 8'd0 && out_r.green == 8'd0 && out_r.blue == 8'd0 && out_r.alpha == 8'd0)
    else $error("error result carries pixel data");

  a_rose_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r && side3_r.cmd == CMD_FETCH))
    else $error("result without a fetch in the read stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

endmodule

// ----- hdl/nnrs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module nnrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/nnrs_cfg.sv -----
// Configuration registers and registered geometry checks.
// Depends on nnrs_pkg.
module nnrs_cfg import nnrs_pkg::*; #(
  parameter int unsigned     MAX_DIM         = DEF_MAX_DIM,
  parameter longint unsigned MAX_PIXEL_COUNT = DEF_MAX_PIXEL_COUNT,
  parameter int unsigned     STORE_WORDS     = DEF_STORE_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [DIM_W-1:0]   src_width_r, src_height_r, out_width_r, out_height_r;
  logic [PITCH_W-1:0] pitch_r;
  logic               bgra_r, flip_r, src_bad_r, out_bad_r;
  logic               src_bad_nxt, out_bad_nxt;
  logic [2*DIM_W-1:0] src_area, out_area;
  logic [PITCH_W+DIM_W:0] src_span;
  logic [DIM_W-1:0]   src_hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= '0;
      src_height_r <= '0;
      pitch_r      <= '0;
      out_width_r  <= '0;
      out_height_r <= '0;
      bgra_r       <= 1'b0;
      flip_r       <= 1'b0;
      src_bad_r    <= 1'b1;
      out_bad_r    <= 1'b1;
    end else begin
      src_bad_r <= src_bad_nxt;
      out_bad_r <= out_bad_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[DIM_W-1:0];
          REG_SRC_HEIGHT: src_height_r <= cfg_wdata[DIM_W-1:0];
          REG_ROW_PITCH:  pitch_r      <= cfg_wdata[PITCH_W-1:0];
          REG_OUT_WIDTH:  out_width_r  <= cfg_wdata[DIM_W-1:0];
          REG_OUT_HEIGHT: out_height_r <= cfg_wdata[DIM_W-1:0];
          REG_BGRA_ORDER: bgra_r       <= cfg_wdata[0];
          REG_FLIP_ROWS:  flip_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    src_area = (2*DIM_W)'(src_width_r) * (2*DIM_W)'(src_height_r);
    out_area = (2*DIM_W)'(out_width_r) * (2*DIM_W)'(out_height_r);
    src_hm1  = src_height_r - DIM_W'(1);
    src_span = (PITCH_W+DIM_W+1)'(pitch_r) * (PITCH_W+DIM_W+1)'(src_hm1)
             + (PITCH_W+DIM_W+1)'(src_width_r);
    out_bad_nxt = (out_width_r == '0) || (out_height_r == '0)
               || (32'(out_width_r) > 32'(MAX_DIM)) || (32'(out_height_r) > 32'(MAX_DIM))
               || (64'(out_area) > 64'(MAX_PIXEL_COUNT));
    src_bad_nxt = (src_width_r == '0) || (src_height_r == '0)
               || (32'(src_width_r) > 32'(MAX_DIM)) || (32'(src_height_r) > 32'(MAX_DIM))
               || (64'(src_area) > 64'(MAX_PIXEL_COUNT))
               || (pitch_r < PITCH_W'(src_width_r))
               || (64'(src_span) > 64'(STORE_WORDS));
  end

  assign cfg = '{src_width: src_width_r, src_height: src_height_r,
                 row_pitch_words: pitch_r, out_width: out_width_r,
                 out_height: out_height_r, bgra_order: bgra_r, flip_rows: flip_r,
                 src_bad: src_bad_r, out_bad: out_bad_r};

endmodule

// ----- hdl/nnrs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nnrs_pkg.
module nnrs_div import nnrs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned RW = NUM_W + 1;

  logic [RW-1:0]    rem_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned SH = QUO_W - 1 - k;
    logic [RW-1:0]    rem_in, dsh;
    logic [QUO_W-1:0] quo_in;
    if (k == 0) begin : g_first
      assign rem_in = RW'(num);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
    end
    assign dsh = RW'(den) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= dsh) begin
          rem_r[k] <= rem_in - dsh;
          quo_r[k] <= quo_in | (QUO_W'(1) << SH);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule
